@@ rtl/core/pid_step_with_antiwindup_assert.svh @@
// Assertion macros for the PID step block.
// Taken in by the modules that check their own logic; no other dependencies.
`ifndef PID_STEP_WITH_ANTIWINDUP_ASSERT_SVH
`define PID_STEP_WITH_ANTIWINDUP_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define PSWA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define PSWA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pswa_pkg.sv @@
// Shared types, widths and constants of the PID step block.
// No dependencies; used by pswa_mac, pswa_ctrl and the top level.
`default_nettype none

package pswa_pkg;

   // Datapath widths
   localparam int GAIN_W = 24;
   localparam int ERR_W  = 33;
   localparam int PROD_W = GAIN_W + 1 + ERR_W;
   localparam int ACC_W  = 72;
   localparam int INT_W  = 48;
   localparam int FILT_W = 32;
   localparam int MAG_W  = 58;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Filter coefficients, Q16
   localparam logic [GAIN_W-1:0] ALPHA_Q16       = 24'd2949;
   localparam logic [GAIN_W-1:0] ONE_M_ALPHA_Q16 = 24'd62587;
   localparam logic [ACC_W-1:0]  ROUND_HALF      = 72'd32768;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_DT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_KP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDUP_MODE = 3'd6;

   // Anti-windup modes
   localparam logic [1:0] WINDUP_NONE     = 2'd0;
   localparam logic [1:0] WINDUP_UNDO     = 2'd1;
   localparam logic [1:0] WINDUP_BACKCALC = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_I_LO, ST_I_HI, ST_P, ST_D_MUL, ST_D_LO, ST_D_HI,
      ST_F_ERR, ST_F_FILT, ST_CHECK, ST_BC_LO, ST_BC_MID, ST_BC_HI,
      ST_BC_WB, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      A_KI, A_KP, A_KD, A_INV_DT, A_ALPHA, A_ONE_M_ALPHA, A_INV_KP
   } a_sel_type;

   typedef enum logic [3:0] {
      B_INT_LO, B_INT_HI, B_ERR, B_FILT, B_TMP_LO, B_TMP_HI,
      B_MAG_LO, B_MAG_MID, B_MAG_HI
   } b_sel_type;

   typedef enum logic [2:0] {
      BASE_ZERO, BASE_ACC, BASE_ACC_SHR, BASE_TMP, BASE_TMP_SHR
   } base_sel_type;

   typedef enum logic [1:0] {
      SH_NONE, SH_RIGHT16, SH_LEFT16, SH_LEFT32
   } prod_sh_type;

   typedef enum logic {
      DEST_ACC, DEST_TMP
   } dest_type;

   typedef struct packed {
      logic         en;
      a_sel_type    a_sel;
      b_sel_type    b_sel;
      base_sel_type base_sel;
      prod_sh_type  prod_sh;
      dest_type     dest;
   } mac_ctrl_type;

   typedef struct packed {
      mac_ctrl_type mac;
      logic         check;
      logic         bc_wb;
      logic         load_rsp;
   } seq_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/core/pswa_mac.sv @@
// Shared multiply-accumulate unit: one 25x33 signed multiplier, a shift and
// a 72-bit add into either the accumulator or the scratch register. Uses pswa_pkg.
`default_nettype none

module pswa_mac (
   input  wire                                   clock,
   input  wire pswa_pkg::mac_ctrl_type           ctrl,
   input  wire logic [pswa_pkg::GAIN_W-1:0]      a,
   input  wire logic signed [pswa_pkg::ERR_W-1:0] b,
   output logic signed [pswa_pkg::ACC_W-1:0]     acc,
   output logic signed [pswa_pkg::ACC_W-1:0]     tmp
);

   logic signed [pswa_pkg::PROD_W-1:0] prod;
   logic signed [pswa_pkg::ACC_W-1:0]  prod_ext;
   logic signed [pswa_pkg::ACC_W-1:0]  prod_sh;
   logic signed [pswa_pkg::ACC_W-1:0]  base;
   logic signed [pswa_pkg::ACC_W-1:0]  sum_in;
   logic signed [pswa_pkg::ACC_W-1:0]  acc_ff;
   logic signed [pswa_pkg::ACC_W-1:0]  tmp_ff;

   // Multiply unsigned gain by signed operand
   assign prod     = $signed({1'b0, a}) * b;
   assign prod_ext = $signed({{(pswa_pkg::ACC_W - pswa_pkg::PROD_W){prod[pswa_pkg::PROD_W-1]}},
                              prod});

   // Align the product
   always_comb begin
      case (ctrl.prod_sh)
         pswa_pkg::SH_NONE:    prod_sh = prod_ext;
         pswa_pkg::SH_RIGHT16: prod_sh = prod_ext >>> 16;
         pswa_pkg::SH_LEFT16:  prod_sh = prod_ext <<< 16;
         pswa_pkg::SH_LEFT32:  prod_sh = prod_ext <<< 32;
         default:              prod_sh = prod_ext;
      endcase
   end

   // Pick the addend
   always_comb begin
      case (ctrl.base_sel)
         pswa_pkg::BASE_ZERO:    base = '0;
         pswa_pkg::BASE_ACC:     base = acc_ff;
         pswa_pkg::BASE_ACC_SHR: base = acc_ff >>> 16;
         pswa_pkg::BASE_TMP:     base = tmp_ff;
         pswa_pkg::BASE_TMP_SHR: base = tmp_ff >>> 16;
         default:                base = '0;
      endcase
   end

   assign sum_in = base + prod_sh;

   // Write back to the selected register
   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         if (ctrl.dest == pswa_pkg::DEST_ACC) begin
            acc_ff <= sum_in;
         end else begin
            tmp_ff <= sum_in;
         end
      end
   end

   assign acc = acc_ff;
   assign tmp = tmp_ff;

endmodule

`default_nettype wire

@@ rtl/core/pswa_ctrl.sv @@
// Step sequencer: walks the multiply-accumulate unit through the PID terms,
// the filter, the limit check and back-calculation. Uses pswa_pkg.
`default_nettype none

module pswa_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_cmd,
   input  wire                          bc_need,
   input  wire                          rsp_free,
   output logic                         req_ready,
   output pswa_pkg::seq_ctrl_type       seq
);

   pswa_pkg::state_type state_ff;
   pswa_pkg::state_type state_in;

   function automatic pswa_pkg::mac_ctrl_type mac_op(
      input pswa_pkg::a_sel_type    a_sel,
      input pswa_pkg::b_sel_type    b_sel,
      input pswa_pkg::base_sel_type base_sel,
      input pswa_pkg::prod_sh_type  prod_sh,
      input pswa_pkg::dest_type     dest
   );
      pswa_pkg::mac_ctrl_type m;
      m.en       = 1'b1;
      m.a_sel    = a_sel;
      m.b_sel    = b_sel;
      m.base_sel = base_sel;
      m.prod_sh  = prod_sh;
      m.dest     = dest;
      return m;
   endfunction

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pswa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and unit controls
   always_comb begin
      state_in  = state_ff;
      seq       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pswa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = req_cmd ? pswa_pkg::ST_DONE : pswa_pkg::ST_I_LO;
            end
         end
         // integral term: low half, then high half on top of the shifted low part
         pswa_pkg::ST_I_LO: begin
            seq.mac  = mac_op(pswa_pkg::A_KI, pswa_pkg::B_INT_LO, pswa_pkg::BASE_ZERO,
                              pswa_pkg::SH_NONE, pswa_pkg::DEST_ACC);
            state_in = pswa_pkg::ST_I_HI;
         end
         pswa_pkg::ST_I_HI: begin
            seq.mac  = mac_op(pswa_pkg::A_KI, pswa_pkg::B_INT_HI, pswa_pkg::BASE_ACC_SHR,
                              pswa_pkg::SH_NONE, pswa_pkg::DEST_ACC);
            state_in = pswa_pkg::ST_P;
         end
         // proportional term, floored on its own
         pswa_pkg::ST_P: begin
            seq.mac  = mac_op(pswa_pkg::A_KP, pswa_pkg::B_ERR, pswa_pkg::BASE_ACC,
                              pswa_pkg::SH_RIGHT16, pswa_pkg::DEST_ACC);
            state_in = pswa_pkg::ST_D_MUL;
         end
         // derivative: scale filtered error, then times the rate in two halves
         pswa_pkg::ST_D_MUL: begin
            seq.mac  = mac_op(pswa_pkg::A_KD, pswa_pkg::B_FILT, pswa_pkg::BASE_ZERO,
                              pswa_pkg::SH_RIGHT16, pswa_pkg::DEST_TMP);
            state_in = pswa_pkg::ST_D_LO;
         end
         pswa_pkg::ST_D_LO: begin
            seq.mac  = mac_op(pswa_pkg::A_INV_DT, pswa_pkg::B_TMP_LO, pswa_pkg::BASE_ACC,
                              pswa_pkg::SH_NONE, pswa_pkg::DEST_ACC);
            state_in = pswa_pkg::ST_D_HI;
         end
         pswa_pkg::ST_D_HI: begin
            seq.mac  = mac_op(pswa_pkg::A_INV_DT, pswa_pkg::B_TMP_HI, pswa_pkg::BASE_ACC,
                              pswa_pkg::SH_LEFT16, pswa_pkg::DEST_ACC);
            state_in = pswa_pkg::ST_F_ERR;
         end
         // low-pass filter numerator
         pswa_pkg::ST_F_ERR: begin
            seq.mac  = mac_op(pswa_pkg::A_ALPHA, pswa_pkg::B_ERR, pswa_pkg::BASE_ZERO,
                              pswa_pkg::SH_NONE, pswa_pkg::DEST_TMP);
            state_in = pswa_pkg::ST_F_FILT;
         end
         pswa_pkg::ST_F_FILT: begin
            seq.mac  = mac_op(pswa_pkg::A_ONE_M_ALPHA, pswa_pkg::B_FILT, pswa_pkg::BASE_TMP,
                              pswa_pkg::SH_NONE, pswa_pkg::DEST_TMP);
            state_in = pswa_pkg::ST_CHECK;
         end
         pswa_pkg::ST_CHECK: begin
            seq.check = 1'b1;
            state_in  = bc_need ? pswa_pkg::ST_BC_LO : pswa_pkg::ST_DONE;
         end
         // back-calculation: inv_kp times excess magnitude in three slices
         pswa_pkg::ST_BC_LO: begin
            seq.mac  = mac_op(pswa_pkg::A_INV_KP, pswa_pkg::B_MAG_LO, pswa_pkg::BASE_ZERO,
                              pswa_pkg::SH_NONE, pswa_pkg::DEST_TMP);
            state_in = pswa_pkg::ST_BC_MID;
         end
         pswa_pkg::ST_BC_MID: begin
            seq.mac  = mac_op(pswa_pkg::A_INV_KP, pswa_pkg::B_MAG_MID, pswa_pkg::BASE_TMP_SHR,
                              pswa_pkg::SH_NONE, pswa_pkg::DEST_TMP);
            state_in = pswa_pkg::ST_BC_HI;
         end
         pswa_pkg::ST_BC_HI: begin
            seq.mac  = mac_op(pswa_pkg::A_INV_KP, pswa_pkg::B_MAG_HI, pswa_pkg::BASE_TMP,
                              pswa_pkg::SH_LEFT32, pswa_pkg::DEST_TMP);
            state_in = pswa_pkg::ST_BC_WB;
         end
         pswa_pkg::ST_BC_WB: begin
            seq.bc_wb = 1'b1;
            state_in  = pswa_pkg::ST_DONE;
         end
         // hold until the output register is free
         pswa_pkg::ST_DONE: begin
            if (rsp_free) begin
               seq.load_rsp = 1'b1;
               state_in     = pswa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pswa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/pid_step_with_antiwindup.sv @@
// PID controller step with filtered derivative, drive limit and anti-windup.
// Input channel req_* (valid/ready): cmd, setpoint, measured, Q16.16.
// Result channel rsp_* (valid/ready): drive (Q16.16) and clamped flag.
// Register port csr_*: write enable, index, data; registers kp, ki, kd,
// inv_dt, inv_kp, drive_limit, windup_mode, written while the block is idle (a user rule the block does not enforce).
// One word is worked on at a time; req_ready is high only when no word is in work.
// rsp_valid rises when the result is loaded into the output register, after the
// integral, proportional, derivative, filter and limit-check steps, and the
// back-calculation steps when they run; a clear command goes straight to the load.
// req_ready comes back with the result. The steps are sequenced through the single
// shared 25x33 multiply-accumulate unit, which the sequencer drives term by term.
// The result sits in an output register: if the receiver stalls, the block
// finishes the next word's arithmetic and then holds it until the register frees.
// Synchronous reset clears the integral, the filtered error, the registers to
// their defaults and drops any word in work or waiting.
// Uses pswa_pkg, pswa_mac, pswa_ctrl and the assertion macro header.
`default_nettype none
`include "pid_step_with_antiwindup_assert.svh"

module pid_step_with_antiwindup (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire                                     req_cmd,
   input  wire logic signed [31:0]                 req_setpoint,
   input  wire logic signed [31:0]                 req_measured,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [31:0]                      rsp_drive,
   output logic                                    rsp_clamped,
   input  wire                                     csr_we,
   input  wire logic [pswa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pswa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ACC_W = pswa_pkg::ACC_W;
   localparam int INT_W = pswa_pkg::INT_W;
   localparam int MAG_W = pswa_pkg::MAG_W;

   // configuration registers
   logic [23:0] kp_ff, ki_ff, kd_ff, inv_kp_ff;
   logic [15:0] inv_dt_ff;
   logic [30:0] drive_limit_ff;
   logic [1:0]  windup_mode_ff;

   // loop state and work registers
   logic signed [INT_W-1:0]           int_ff;
   logic signed [pswa_pkg::FILT_W-1:0] fe_ff;
   logic signed [pswa_pkg::ERR_W-1:0]  e_ff;
   logic [31:0]                        drive_ff;
   logic                               clamp_ff;
   logic [MAG_W-1:0]                   mag_ff;
   logic                               exc_neg_ff;
   logic                               rsp_valid_ff;
   logic [31:0]                        rsp_drive_ff;
   logic                               rsp_clamped_ff;

   pswa_pkg::seq_ctrl_type             seq;
   logic                               req_fire;
   logic                               rsp_free;
   logic [pswa_pkg::GAIN_W-1:0]        mac_a;
   logic signed [pswa_pkg::ERR_W-1:0]  mac_b;
   logic signed [ACC_W-1:0]            acc;
   logic signed [ACC_W-1:0]            tmp;

   logic signed [ACC_W-1:0]            lim_s, neg_lim_s;
   logic [31:0]                        lim32, neg_lim32;
   logic                               over, clamp_in, bc_need;
   logic [31:0]                        drive_in;
   logic signed [ACC_W-1:0]            excess, mag_full;
   logic signed [ACC_W-1:0]            fround, fshift;
   logic [31:0]                        fe_in;
   logic signed [INT_W:0]              int_sum;
   logic [INT_W-1:0]                   int_plus_in;
   logic                               int_take;
   logic                               c_over;
   logic [49:0]                        c_sat;
   logic signed [51:0]                 int_ext, int_bc;
   logic [INT_W-1:0]                   int_bc_in;

   function automatic logic [31:0] sat_i32(input logic signed [ACC_W-1:0] x);
      logic fits;
      fits = (&x[ACC_W-1:31]) || !(|x[ACC_W-1:31]);
      if (fits) begin
         return x[31:0];
      end
      return x[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   pswa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .bc_need   (bc_need),
      .rsp_free  (rsp_free),
      .req_ready (req_ready),
      .seq       (seq)
   );

   pswa_mac u_mac (
      .clock (clock),
      .ctrl  (seq.mac),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (acc),
      .tmp   (tmp)
   );

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff          <= '0;
         ki_ff          <= '0;
         kd_ff          <= '0;
         inv_dt_ff      <= 16'd1000;
         inv_kp_ff      <= '0;
         drive_limit_ff <= 31'h7FFF_FFFF;
         windup_mode_ff <= pswa_pkg::WINDUP_NONE;
      end else if (csr_we) begin
         case (csr_index)
            pswa_pkg::CSR_KP:          kp_ff          <= csr_wdata[23:0];
            pswa_pkg::CSR_KI:          ki_ff          <= csr_wdata[23:0];
            pswa_pkg::CSR_KD:          kd_ff          <= csr_wdata[23:0];
            pswa_pkg::CSR_INV_DT:      inv_dt_ff      <= csr_wdata[15:0];
            pswa_pkg::CSR_INV_KP:      inv_kp_ff      <= csr_wdata[23:0];
            pswa_pkg::CSR_DRIVE_LIMIT: drive_limit_ff <= csr_wdata;
            pswa_pkg::CSR_WINDUP_MODE: windup_mode_ff <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // Select multiplier operands
   always_comb begin
      case (seq.mac.a_sel)
         pswa_pkg::A_KI:          mac_a = ki_ff;
         pswa_pkg::A_KP:          mac_a = kp_ff;
         pswa_pkg::A_KD:          mac_a = kd_ff;
         pswa_pkg::A_INV_DT:      mac_a = {8'd0, inv_dt_ff};
         pswa_pkg::A_ALPHA:       mac_a = pswa_pkg::ALPHA_Q16;
         pswa_pkg::A_ONE_M_ALPHA: mac_a = pswa_pkg::ONE_M_ALPHA_Q16;
         pswa_pkg::A_INV_KP:      mac_a = inv_kp_ff;
         default:                 mac_a = '0;
      endcase
   end

   always_comb begin
      case (seq.mac.b_sel)
         pswa_pkg::B_INT_LO:  mac_b = {17'd0, int_ff[15:0]};
         pswa_pkg::B_INT_HI:  mac_b = {int_ff[INT_W-1], int_ff[INT_W-1:16]};
         pswa_pkg::B_ERR:     mac_b = e_ff;
         pswa_pkg::B_FILT:    mac_b = {fe_ff[31], fe_ff};
         pswa_pkg::B_TMP_LO:  mac_b = {17'd0, tmp[15:0]};
         pswa_pkg::B_TMP_HI:  mac_b = {{9{tmp[39]}}, tmp[39:16]};
         pswa_pkg::B_MAG_LO:  mac_b = {17'd0, mag_ff[15:0]};
         pswa_pkg::B_MAG_MID: mac_b = {1'b0, mag_ff[47:16]};
         pswa_pkg::B_MAG_HI:  mac_b = {23'd0, mag_ff[MAG_W-1:48]};
         default:             mac_b = '0;
      endcase
   end

   // Limit check on the finished sum
   assign lim32     = {1'b0, drive_limit_ff};
   assign neg_lim32 = 32'd0 - lim32;
   assign lim_s     = $signed({{(ACC_W - 31){1'b0}}, drive_limit_ff});
   assign neg_lim_s = -lim_s;
   assign over      = (acc > lim_s) || (acc < neg_lim_s);
   assign clamp_in  = ((windup_mode_ff == pswa_pkg::WINDUP_UNDO) ||
                       (windup_mode_ff == pswa_pkg::WINDUP_BACKCALC)) && over;
   assign drive_in  = clamp_in ? ((acc > 0) ? lim32 : neg_lim32) : sat_i32(acc);
   assign bc_need   = clamp_in && (windup_mode_ff == pswa_pkg::WINDUP_BACKCALC) &&
                      (kp_ff != '0);

   // Excess over the limit, as magnitude and sign
   assign excess   = acc - $signed({{(ACC_W - 32){drive_in[31]}}, drive_in});
   assign mag_full = excess[ACC_W-1] ? -excess : excess;

   // Round and saturate the new filtered error
   assign fround = tmp + $signed(pswa_pkg::ROUND_HALF);
   assign fshift = fround >>> 16;
   assign fe_in  = sat_i32(fshift);

   // Integrate this step's error
   assign int_sum     = {int_ff[INT_W-1], int_ff} + {{(INT_W + 1 - pswa_pkg::ERR_W){e_ff[32]}}, e_ff};
   assign int_plus_in = (int_sum[INT_W] == int_sum[INT_W-1]) ? int_sum[INT_W-1:0] :
                        (int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}});
   assign int_take    = (ki_ff != '0) &&
                        !(clamp_in && (windup_mode_ff == pswa_pkg::WINDUP_UNDO));

   // Back-calculation correction, capped at 2^49
   assign c_over    = (|tmp[ACC_W-1:50]) || (tmp[49] && (|tmp[48:0]));
   assign c_sat     = c_over ? {1'b1, 49'd0} : tmp[49:0];
   assign int_ext   = {{4{int_ff[INT_W-1]}}, int_ff};
   assign int_bc    = exc_neg_ff ? (int_ext + $signed({2'b00, c_sat}))
                                 : (int_ext - $signed({2'b00, c_sat}));
   assign int_bc_in = ((&int_bc[51:47]) || !(|int_bc[51:47])) ? int_bc[INT_W-1:0] :
                      (int_bc[51] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}});

   // Hold the loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff <= '0;
         fe_ff  <= '0;
      end else begin
         if (req_fire && req_cmd) begin
            int_ff <= '0;
         end else if (seq.check && int_take) begin
            int_ff <= int_plus_in;
         end else if (seq.bc_wb) begin
            int_ff <= int_bc_in;
         end
         if (seq.check) begin
            fe_ff <= fe_in;
         end
      end
   end

   // Capture the error and the step result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         e_ff <= $signed({req_setpoint[31], req_setpoint}) -
                 $signed({req_measured[31], req_measured});
      end
      if (req_fire && req_cmd) begin
         drive_ff <= '0;
         clamp_ff <= 1'b0;
      end else if (seq.check) begin
         drive_ff   <= drive_in;
         clamp_ff   <= clamp_in;
         mag_ff     <= mag_full[MAG_W-1:0];
         exc_neg_ff <= excess[ACC_W-1];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq.load_rsp) begin
         rsp_drive_ff   <= drive_ff;
         rsp_clamped_ff <= clamp_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

   `PSWA_ASSERT_IMPLIES(a_clamp_on_limit, clock, reset, rsp_valid_ff && rsp_clamped_ff, (rsp_drive_ff == lim32) || (rsp_drive_ff == neg_lim32), "clamped drive is not at the limit")
   `PSWA_ASSERT_IMPLIES(a_clamp_mode, clock, reset, rsp_valid_ff && rsp_clamped_ff, (windup_mode_ff == pswa_pkg::WINDUP_UNDO) || (windup_mode_ff == pswa_pkg::WINDUP_BACKCALC), "clamp flagged with limiting off")
   `PSWA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "word accepted while one is in work")
   `PSWA_ASSERT_NEXT(a_clear_keeps_filter, clock, reset, req_fire && req_cmd, $stable(fe_ff) && (int_ff == '0) && (drive_ff == '0), "clear command disturbed state")
   `PSWA_ASSERT_IMPLIES(a_backcalc_gate, clock, reset, seq.bc_wb, clamp_ff && (windup_mode_ff == pswa_pkg::WINDUP_BACKCALC) && (kp_ff != '0), "back-calculation without a clamp")

endmodule

`default_nettype wire

@@ test/tb_pid_step_with_antiwindup.sv @@
// Testbench for pid_step_with_antiwindup: drives random and directed words,
// predicts drive and clamp flag per word and checks them in order.
// Depends on pswa_pkg and the pid_step_with_antiwindup RTL.

module tb_pid_step_with_antiwindup;

   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Windup code with no mode of its own; behaves as no limiting
   localparam logic [1:0] WINDUP_SPARE = 2'd3;

   localparam longint I48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint I48_MIN = -I48_MAX - 1;
   localparam longint I32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint I32_MIN = -I32_MAX - 1;
   localparam longint FILT_ROUND = 32768;
   localparam longint unsigned BC_CAP = 64'd1 << 49;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 32;
   localparam int PHASE_WORDS   = 128;

   typedef struct packed {
      logic        cmd;
      logic [31:0] setpoint;
      logic [31:0] measured;
   } pid_word_type;

   typedef struct packed {
      logic [31:0] drive;
      logic        clamped;
   } drive_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = 1'b0;
   logic signed [31:0] req_setpoint = '0;
   logic signed [31:0] req_measured = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_drive;
   logic rsp_clamped;
   logic csr_we = 1'b0;
   logic [pswa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pswa_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Controller registers and state as the predictor sees them
   longint gain_kp = 0;
   longint gain_ki = 0;
   longint gain_kd = 0;
   longint rate_hz = 1000;
   longint gain_inv_kp = 0;
   longint drive_lim = 64'sh7FFF_FFFF;
   logic [1:0] windup_sel = pswa_pkg::WINDUP_NONE;
   longint integral_acc = 0;
   longint filt_err = 0;

   pid_word_type pending_words[$];
   drive_result_type expected_drives[$];

   int words_offered = 0;
   int words_accepted = 0;
   int fault_count = 0;
   int cycle_count = 0;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;

   pid_step_with_antiwindup DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_setpoint(req_setpoint),
      .req_measured(req_measured),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive(rsp_drive),
      .rsp_clamped(rsp_clamped),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic longint clip(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // Compute one control step and advance the integral and filter
   function automatic drive_result_type predict_drive(pid_word_type w);
      longint e, p, i_term, d, total, num, prev_int, lim, drv, excess, c, hi, lo, sat_sum;
      longint unsigned mag, mh, ml, inv_u;
      drive_result_type r;
      r.drive = '0;
      r.clamped = 1'b0;
      if (w.cmd == CMD_CLEAR) begin
         integral_acc = 0;
         return r;
      end
      e = longint'($signed(w.setpoint)) - longint'($signed(w.measured));
      p = (gain_kp * e) >>> 16;
      // split the integral so the gain product stays within 64 bits
      hi = integral_acc >>> 16;
      lo = integral_acc - hi * 65536;
      i_term = gain_ki * hi + ((gain_ki * lo) >>> 16);
      d = ((gain_kd * filt_err) >>> 16) * rate_hz;
      total = p + i_term + d;

      // low-pass the error, rounded, saturated to 32 bits
      num = longint'(pswa_pkg::ALPHA_Q16) * e
          + longint'(pswa_pkg::ONE_M_ALPHA_Q16) * filt_err + FILT_ROUND;
      filt_err = clip(num >>> 16, I32_MIN, I32_MAX);

      prev_int = integral_acc;
      if (gain_ki != 0)
         integral_acc = clip(integral_acc + e, I48_MIN, I48_MAX);

      lim = drive_lim;
      if ((windup_sel == pswa_pkg::WINDUP_UNDO || windup_sel == pswa_pkg::WINDUP_BACKCALC) &&
          (total > lim || total < -lim)) begin
         r.clamped = 1'b1;
         drv = (total > 0) ? lim : -lim;
         if (windup_sel == pswa_pkg::WINDUP_UNDO) begin
            integral_acc = prev_int;
         end else if (gain_kp != 0) begin
            // back-calculate: remove the excess scaled by 1/kp
            excess = total - drv;
            if (excess < 0) mag = -excess;
            else mag = excess;
            mh = mag >> 16;
            ml = mag & 64'hFFFF;
            inv_u = gain_inv_kp;
            if (mh != 0 && inv_u > BC_CAP / mh)
               c = BC_CAP;
            else
               c = inv_u * mh + ((inv_u * ml) >> 16);
            if (c > longint'(BC_CAP))
               c = BC_CAP;
            if (excess < 0)
               c = -c;
            integral_acc = clip(integral_acc - c, I48_MIN, I48_MAX);
         end
         r.drive = drv[31:0];
      end else begin
         sat_sum = clip(total, I32_MIN, I32_MAX);
         r.drive = sat_sum[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] rand_q16();
      logic [31:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         1, 2, 3, 4: v = $urandom_range(32'h003F_FFFF) - 32'h0020_0000;
         5, 6: v = $urandom_range(32'h0FFF_FFFF) - 32'h0800_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic pid_word_type rand_word();
      pid_word_type w;
      w.cmd = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_STEP;
      w.setpoint = rand_q16();
      // often track the setpoint closely, as a running loop would
      if ($urandom_range(9) < 3)
         w.measured = w.setpoint - ($urandom_range(32'h000F_FFFF) - 32'h0008_0000);
      else
         w.measured = rand_q16();
      return w;
   endfunction

   task automatic queue_step(logic cmd, logic [31:0] sp, logic [31:0] ms);
      pid_word_type w;
      w.cmd = cmd;
      w.setpoint = sp;
      w.measured = ms;
      pending_words.push_back(w);
   endtask

   // Hold the write enable high across back-to-back register writes
   task automatic write_reg(logic [pswa_pkg::CSR_IDX_W-1:0] idx, longint unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[pswa_pkg::CSR_DATA_W-1:0];
      case (idx)
         pswa_pkg::CSR_KP:          gain_kp = val & 64'hFF_FFFF;
         pswa_pkg::CSR_KI:          gain_ki = val & 64'hFF_FFFF;
         pswa_pkg::CSR_KD:          gain_kd = val & 64'hFF_FFFF;
         pswa_pkg::CSR_INV_DT:      rate_hz = val & 64'hFFFF;
         pswa_pkg::CSR_INV_KP:      gain_inv_kp = val & 64'hFF_FFFF;
         pswa_pkg::CSR_DRIVE_LIMIT: drive_lim = val & 64'h7FFF_FFFF;
         pswa_pkg::CSR_WINDUP_MODE: windup_sel = val[1:0];
         default: ;
      endcase
   endtask

   task automatic close_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_regs(longint unsigned kp, longint unsigned ki, longint unsigned kd,
                               longint unsigned rate, longint unsigned inv_kp,
                               longint unsigned lim, longint unsigned mode);
      write_reg(pswa_pkg::CSR_KP, kp);
      write_reg(pswa_pkg::CSR_KI, ki);
      write_reg(pswa_pkg::CSR_KD, kd);
      write_reg(pswa_pkg::CSR_INV_DT, rate);
      write_reg(pswa_pkg::CSR_INV_KP, inv_kp);
      write_reg(pswa_pkg::CSR_DRIVE_LIMIT, lim);
      write_reg(pswa_pkg::CSR_WINDUP_MODE, mode);
      close_writes();
   endtask

   // Wait until every queued word is taken and every result has come back
   task automatic wait_quiet();
      do @(negedge clock);
      while (!(pending_words.size() == 0 && words_offered == words_accepted &&
               expected_drives.size() == 0));
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer words from the pending queue; hold each until it is taken
   always @(negedge clock) begin : drive_req
      pid_word_type nxt;
      if (!reset && !(req_valid && words_offered != words_accepted)) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            nxt = pending_words.pop_front();
            req_valid <= 1'b1;
            req_cmd <= nxt.cmd;
            req_setpoint <= nxt.setpoint;
            req_measured <= nxt.measured;
            // count at once so the quiet check never sees a popped word as gone
            words_offered = words_offered + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random, or for a long stretch on request
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check results against the oldest prediction; predict each accepted word
   always @(posedge clock) begin : watch_channels
      drive_result_type want;
      pid_word_type taken;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result word: drive %0d clamped %0b",
                           rsp_drive, rsp_clamped);
            end else begin
               want = expected_drives.pop_front();
               if (rsp_drive !== want.drive || rsp_clamped !== want.clamped) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch: drive exp %0d got %0d, clamped exp %0b got %0b",
                              $signed(want.drive), rsp_drive, want.clamped, rsp_clamped);
               end
            end
         end
         if (req_valid && req_ready) begin
            taken.cmd = req_cmd;
            taken.setpoint = req_setpoint;
            taken.measured = req_measured;
            expected_drives.push_back(predict_drive(taken));
            words_accepted <= words_accepted + 1;
         end
      end
   end

   initial begin : stimulus
      int ph;
      int n;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed words: field extremes, clear, clamping both ways
      program_regs(24'h01_0000, 24'h00_0800, 24'h00_0400, 1000, 24'h01_0000,
                   32'd100 << 16, pswa_pkg::WINDUP_BACKCALC);
      queue_step(CMD_STEP, 32'h0000_0000, 32'h0000_0000);
      queue_step(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_step(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_step(CMD_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_step(CMD_STEP, 32'h8000_0000, 32'h8000_0000);
      queue_step(CMD_STEP, 32'h0000_0001, 32'hFFFF_FFFF);
      repeat (5) queue_step(CMD_STEP, 32'h000A_0000, 32'h0000_0000);
      queue_step(CMD_CLEAR, 32'h7FFF_FFFF, 32'h8000_0000);
      repeat (3) queue_step(CMD_STEP, 32'hFFCE_0000, 32'h0032_0000);
      repeat (4) queue_step(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
      repeat (2) queue_step(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_step(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
      wait_quiet();

      // Zero rate and the unused windup code
      write_reg(pswa_pkg::CSR_INV_DT, 0);
      write_reg(pswa_pkg::CSR_WINDUP_MODE, WINDUP_SPARE);
      close_writes();
      queue_step(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_step(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_step(CMD_STEP, 32'h0064_0000, 32'h0000_0000);

      // Random phases, each with its own register setting, cycling through four idle patterns
      for (ph = 0; ph < 8; ph++) begin
         wait_quiet();
         case (ph)
            0: program_regs(24'h01_0000, 24'h00_0800, 24'h00_0400, 1000, 24'h01_0000,
                            32'd100 << 16, pswa_pkg::WINDUP_BACKCALC);
            1: program_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 65535, 24'hFF_FFFF,
                            32'h7FFF_FFFF, pswa_pkg::WINDUP_UNDO);
            2: program_regs(0, 24'h00_0100, 0, 1, 24'h00_8000, 0, pswa_pkg::WINDUP_BACKCALC);
            3: program_regs(24'h02_0000, 0, 24'h00_1000, 0, 0, 1000, pswa_pkg::WINDUP_NONE);
            4: program_regs(24'h00_8000, 24'h00_0040, 24'h00_0010, 50000, 24'h02_0000,
                            32'd10 << 16, WINDUP_SPARE);
            5: program_regs(24'h03_0000, 24'h00_1000, 24'h00_0200, 100, 24'h00_5555,
                            32'h7FFF, pswa_pkg::WINDUP_UNDO);
            6: program_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'h00_0800, 2000, 24'hFF_FFFF,
                            1, pswa_pkg::WINDUP_BACKCALC);
            default: program_regs($urandom_range(24'hFF_FFFF), $urandom_range(24'hFF_FFFF),
                                  $urandom_range(24'hFF_FFFF), $urandom_range(65535, 1),
                                  $urandom_range(24'hFF_FFFF), $urandom_range(32'h7FFF_FFFF),
                                  $urandom_range(2));
         endcase
         case (ph % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 65; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 65; end
            default: begin send_gap_pct = 16; rsp_stall_pct = 16; end
         endcase
         // back up the block behind a long receiver stall
         if (ph == 0)
            hold_requests++;
         for (n = 0; n < PHASE_WORDS; n++) begin
            // let the block drain completely halfway through
            if (ph == 1 && n == PHASE_WORDS / 2)
               wait_quiet();
            pending_words.push_back(rand_word());
         end
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0 && expected_drives.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
